@@ design/mcfe_pkg.sv @@
// Shared types and constants for the motor command frame encoder.
// Lane constants for the setpoint scaling, kind decode and the queue entry type.
// No dependencies.
package mcfe_pkg;

	localparam int NUM_LANES   = 5;
	localparam int SET_W       = 24;
	localparam int ID_W        = 11;
	localparam int FRAME_W     = 64;
	localparam int NUM_W       = 22;   // clamped setpoint minus its minimum
	localparam int VAL_W       = 22;   // scaled numerator after the power-of-two shift
	localparam int RECIP_SHIFT = 22;
	localparam int RECIP_W     = 20;
	localparam int PROD_W      = VAL_W + RECIP_W;
	localparam int ODD_W       = 8;
	localparam int CODE_W      = 16;
	localparam int WIDE_W      = NUM_W + CODE_W;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = QPTR_W + 1;

	localparam int S_TDATA_W = 136;
	localparam int S_TUSER_W = 3;
	localparam int M_TDATA_W = 80;

	// Lanes: position, velocity, kp, kd, torque
	localparam logic signed [SET_W-1:0] LANE_LO [NUM_LANES] = '{
		-24'sd104448, -24'sd184320, 24'sd0, 24'sd0, -24'sd73728
	};
	localparam logic signed [SET_W-1:0] LANE_HI [NUM_LANES] = '{
		24'sd104448, 24'sd184320, 24'sd2048000, 24'sd20480, 24'sd73728
	};
	localparam int LANE_BITS [NUM_LANES] = '{16, 12, 12, 12, 12};
	// span = 2^k * odd
	localparam int LANE_K    [NUM_LANES] = '{12, 13, 14, 12, 14};
	localparam logic [ODD_W-1:0] LANE_ODD [NUM_LANES] = '{
		8'd51, 8'd45, 8'd125, 8'd5, 8'd9
	};
	// floor(2^RECIP_SHIFT / odd)
	localparam logic [RECIP_W-1:0] LANE_RECIP [NUM_LANES] = '{
		RECIP_W'((2**RECIP_SHIFT) / 51),
		RECIP_W'((2**RECIP_SHIFT) / 45),
		RECIP_W'((2**RECIP_SHIFT) / 125),
		RECIP_W'((2**RECIP_SHIFT) / 5),
		RECIP_W'((2**RECIP_SHIFT) / 9)
	};

	typedef enum logic [2:0] {
		KIND_CONTROL    = 3'd0,
		KIND_SPEED_MODE = 3'd1,
		KIND_POS_MODE   = 3'd2,
		KIND_ENTER      = 3'd3,
		KIND_EXIT       = 3'd4,
		KIND_TURN_RESET = 3'd5,
		KIND_ZERO       = 3'd6
	} kind_t;

	localparam logic [7:0] CMD_SPEED_MODE = 8'hFA;
	localparam logic [7:0] CMD_POS_MODE   = 8'hFB;
	localparam logic [7:0] CMD_ENTER      = 8'hFC;
	localparam logic [7:0] CMD_EXIT       = 8'hFD;
	localparam logic [7:0] CMD_TURN_RESET = 8'hFE;
	localparam logic [7:0] CMD_ZERO       = 8'hFF;
	localparam logic [55:0] CMD_PREFIX    = 56'hFF_FFFF_FFFF_FFFF;

	typedef struct packed {
		logic                        is_ctrl;
		logic [7:0]                  cmd_byte;
		logic [ID_W-1:0]             node_id;
		logic [NUM_LANES-1:0][SET_W-1:0] setp;
	} queue_entry_t;

	typedef struct packed {
		logic empty;
		logic full;
	} queue_status_t;

endpackage

@@ design/mcfe_front.sv @@
// Front end: takes input beats, decodes the kind and builds the queue entry.
// Depends on mcfe_pkg. Unused kind codes are dropped here.
module mcfe_front (
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	// node_id[10:0], position_set[34:11], velocity_set[58:35],
	// stiffness_gain[82:59], damping_gain[106:83], torque_feedforward[130:107], zero pad
	input  logic [mcfe_pkg::S_TDATA_W-1:0]  s_axis_tdata,
	// kind[2:0]
	input  logic [mcfe_pkg::S_TUSER_W-1:0]  s_axis_tuser,
	input  mcfe_pkg::queue_status_t         q_status,
	output logic                            push,
	output mcfe_pkg::queue_entry_t          push_entry
);
	import mcfe_pkg::*;

	logic       valid_kind;
	logic [7:0] cmd;

	always_comb begin
		valid_kind = 1'b1;
		cmd        = CMD_ZERO;
		case (s_axis_tuser)
			KIND_CONTROL:    cmd = CMD_ZERO;
			KIND_SPEED_MODE: cmd = CMD_SPEED_MODE;
			KIND_POS_MODE:   cmd = CMD_POS_MODE;
			KIND_ENTER:      cmd = CMD_ENTER;
			KIND_EXIT:       cmd = CMD_EXIT;
			KIND_TURN_RESET: cmd = CMD_TURN_RESET;
			KIND_ZERO:       cmd = CMD_ZERO;
			default:         valid_kind = 1'b0;
		endcase
	end

	assign s_axis_tready = !q_status.full;
	// a beat with no meaningful kind is taken and discarded
	assign push          = s_axis_tvalid && s_axis_tready && valid_kind;

	always_comb begin
		push_entry.is_ctrl  = (s_axis_tuser == KIND_CONTROL);
		push_entry.cmd_byte = cmd;
		push_entry.node_id  = s_axis_tdata[ID_W-1:0];
		for (int i = 0; i < NUM_LANES; i++) begin
			push_entry.setp[i] = s_axis_tdata[ID_W + i*SET_W +: SET_W];
		end
	end

endmodule

@@ design/mcfe_queue.sv @@
// Short queue between the front end and the scaling pipeline.
// Depends on mcfe_pkg for the entry type and depth.
module mcfe_queue (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push,
	input  mcfe_pkg::queue_entry_t  push_entry,
	input  logic                    pop,
	output mcfe_pkg::queue_entry_t  head,
	output mcfe_pkg::queue_status_t status
);
	import mcfe_pkg::*;

	queue_entry_t      slots_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign head         = slots_q[rd_ptr_q];
	assign status.empty = (count_q == '0);
	assign status.full  = (count_q == QCNT_W'(QUEUE_DEPTH));

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

@@ design/mcfe_back.sv @@
// Back end: five-stage scaling pipeline, the last stage being the output register.
// Depends on mcfe_pkg. Stages: clamp, scale, reciprocal multiply, remainder, fix and pack.
module mcfe_back (
	input  logic                            clk,
	input  logic                            arst_n,
	input  mcfe_pkg::queue_entry_t          head,
	input  mcfe_pkg::queue_status_t         q_status,
	output logic                            pop,
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// frame_id[10:0], frame_bytes[74:11], zero pad
	output logic [mcfe_pkg::M_TDATA_W-1:0]  m_axis_tdata
);
	import mcfe_pkg::*;

	logic adv;
	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;

	typedef struct packed {
		logic            is_ctrl;
		logic [7:0]      cmd_byte;
		logic [ID_W-1:0] node_id;
	} tag_t;

	tag_t tag_s1, tag_s2, tag_s3, tag_s4;

	logic [NUM_LANES-1:0][NUM_W-1:0]   num_s1;
	logic [NUM_LANES-1:0][VAL_W-1:0]   val_s2, val_s3;
	logic [NUM_LANES-1:0][PROD_W-1:0]  prod_s3;
	logic [NUM_LANES-1:0][CODE_W-1:0]  qest_s4;
	logic [NUM_LANES-1:0][ODD_W-1:0]   rem_s4;
	logic [NUM_LANES-1:0][CODE_W-1:0]  code;

	logic [ID_W-1:0]    frame_id_s5;
	logic [FRAME_W-1:0] frame_s5;

	// whole pipeline holds while the output beat waits
	assign adv = !valid_s5 || m_axis_tready;
	assign pop = adv && !q_status.empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= !q_status.empty;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			tag_s1 <= '{is_ctrl: head.is_ctrl, cmd_byte: head.cmd_byte, node_id: head.node_id};
			tag_s2 <= tag_s1;
			tag_s3 <= tag_s2;
			tag_s4 <= tag_s3;
		end
	end

	for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
		logic signed [SET_W-1:0]   x;
		logic signed [SET_W-1:0]   x_clamp;
		logic signed [SET_W:0]     off;
		logic [WIDE_W-1:0]         wide;
		logic [WIDE_W-1:0]         scaled;
		logic [VAL_W+ODD_W:0]      back_mul;
		logic [VAL_W+ODD_W:0]      diff;

		always_comb begin
			x = $signed(head.setp[i]);
			if (x < LANE_LO[i]) begin
				x_clamp = LANE_LO[i];
			end else if (x > LANE_HI[i]) begin
				x_clamp = LANE_HI[i];
			end else begin
				x_clamp = x;
			end
			off = {x_clamp[SET_W-1], x_clamp} - {LANE_LO[i][SET_W-1], LANE_LO[i]};
		end

		// num * (2^bits - 1), then drop the power-of-two part of the span
		assign wide   = ({{CODE_W{1'b0}}, num_s1[i]} << LANE_BITS[i]) -
		                {{CODE_W{1'b0}}, num_s1[i]};
		assign scaled = wide >> LANE_K[i];

		assign back_mul = (VAL_W+ODD_W+1)'(prod_s3[i][RECIP_SHIFT +: CODE_W]) *
		                  (VAL_W+ODD_W+1)'(LANE_ODD[i]);
		assign diff     = (VAL_W+ODD_W+1)'(val_s3[i]) - back_mul;

		// reciprocal estimate is low by at most one
		assign code[i] = qest_s4[i] + CODE_W'(rem_s4[i] >= LANE_ODD[i]);

		always_ff @(posedge clk) begin
			if (adv) begin
				num_s1[i]  <= off[NUM_W-1:0];
				val_s2[i]  <= scaled[VAL_W-1:0];
				val_s3[i]  <= val_s2[i];
				prod_s3[i] <= PROD_W'(val_s2[i]) * PROD_W'(LANE_RECIP[i]);
				qest_s4[i] <= prod_s3[i][RECIP_SHIFT +: CODE_W];
				rem_s4[i]  <= diff[ODD_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			frame_id_s5 <= tag_s4.node_id;
			if (tag_s4.is_ctrl) begin
				frame_s5 <= {code[0][15:0], code[1][11:0], code[2][11:0],
				             code[3][11:0], code[4][11:0]};
			end else begin
				frame_s5 <= {CMD_PREFIX, tag_s4.cmd_byte};
			end
		end
	end

	assign m_axis_tvalid = valid_s5;
	assign m_axis_tdata  = {{(M_TDATA_W-FRAME_W-ID_W){1'b0}}, frame_s5, frame_id_s5};

endmodule

@@ design/motor_command_frame_encoder_top.sv @@
// Motor command frame encoder: one 8-byte command frame per input beat.
//
// Input channel s_axis_*: kind on tuser, node id and five Q12 setpoints on tdata.
// Output channel m_axis_*: frame id and eight payload bytes on tdata.
// Control beats have their setpoints clamped and scaled to 16/12-bit codes and
// packed big-endian; command kinds give seven 0xFF bytes and a command byte.
// A beat with the unused kind code is accepted and yields no frame.
// Throughput: one beat per cycle, sustained while the receiver keeps m_axis_tready high.
// Path: with an empty queue, an accepted beat is written to the four-entry queue
// and then read into the first of five pipeline registers, whose stages are set
// by the clamp, the span scaling, the reciprocal multiply and the remainder
// correction, the last one holding the packed frame.
// When the receiver stalls, the output beat holds and the pipeline freezes; the
// queue takes up to four more beats before s_axis_tready drops.
// Reset clears the queue and all valid flags; no frame is pending after it.
// Depends on mcfe_pkg, mcfe_front, mcfe_queue, mcfe_back.
module motor_command_frame_encoder_top (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	// node_id[10:0], position_set[34:11], velocity_set[58:35],
	// stiffness_gain[82:59], damping_gain[106:83], torque_feedforward[130:107], zero pad
	input  logic [mcfe_pkg::S_TDATA_W-1:0]  s_axis_tdata,
	// kind[2:0]
	input  logic [mcfe_pkg::S_TUSER_W-1:0]  s_axis_tuser,
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// frame_id[10:0], frame_bytes[74:11], zero pad
	output logic [mcfe_pkg::M_TDATA_W-1:0]  m_axis_tdata
);
	import mcfe_pkg::*;

	logic          push;
	logic          pop;
	queue_entry_t  push_entry;
	queue_entry_t  head;
	queue_status_t q_status;

	mcfe_front u_front (
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.q_status      (q_status),
		.push          (push),
		.push_entry    (push_entry)
	);

	mcfe_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.status     (q_status)
	);

	mcfe_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head          (head),
		.q_status      (q_status),
		.pop           (pop),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

endmodule

@@ design/mcfe_checker.sv @@
// Port-level checks for the motor command frame encoder, bound to the top level.
// Depends on mcfe_pkg for port widths.
module mcfe_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_axis_tready,
	input logic                            m_axis_tvalid,
	input logic                            m_axis_tready,
	input logic [mcfe_pkg::M_TDATA_W-1:0]  m_axis_tdata
);
	import mcfe_pkg::*;

	// a stalled output beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("output beat changed while stalled");

	// the queue only fills up behind a stalled output
	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> m_axis_tvalid)
		else $error("input held off with no output pending");

	// pad bits above the frame stay clear
	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[M_TDATA_W-1:FRAME_W+ID_W] == '0)
		else $error("output pad bits set");

endmodule

bind motor_command_frame_encoder_top mcfe_checker u_mcfe_checker (.*);

@@ bench/tb_top.sv @@
// Self-checking bench for motor_command_frame_encoder_top: directed and random
// command beats, scoreboard with its own frame predictor, random idling and stalls.
// Depends on mcfe_pkg and the encoder RTL.
module tb_top;
	import mcfe_pkg::*;

	localparam logic [2:0] KIND_UNUSED = 3'd7;

	// Q12 range limits of the five setpoints
	localparam longint Q_ONE   = 4096;
	localparam longint POS_LIM = 51 * Q_ONE / 2;
	localparam longint VEL_LIM = 45 * Q_ONE;
	localparam longint KP_MAX  = 500 * Q_ONE;
	localparam longint KD_MAX  = 5 * Q_ONE;
	localparam longint TQ_LIM  = 18 * Q_ONE;
	localparam longint SET_MIN = -(longint'(1) << (SET_W - 1));
	localparam longint SET_MAX = (longint'(1) << (SET_W - 1)) - 1;

	localparam int RANDOM_ITEMS    = 1550;
	localparam int PRESSURE_CYCLES = 80;
	localparam int DRAIN_CYCLES    = 20;
	localparam int WATCHDOG_LIMIT  = 3000;

	typedef struct packed {
		logic [2:0]       kind;
		logic [ID_W-1:0]  node_id;
		logic [SET_W-1:0] pos;
		logic [SET_W-1:0] vel;
		logic [SET_W-1:0] kp;
		logic [SET_W-1:0] kd;
		logic [SET_W-1:0] tq;
	} motor_cmd_t;

	class frame_scoreboard;
		logic [ID_W-1:0]    pending_ids[$];
		logic [FRAME_W-1:0] pending_frames[$];
		int                 errors;

		function new();
			errors = 0;
		endfunction

		// saturate, offset by the minimum, scale by (2^bits-1)/span, truncate
		static function longint lane_code(logic [SET_W-1:0] raw, longint lo, longint hi,
				int bits);
			longint x;
			x = longint'($signed(raw));
			if (x < lo)
				x = lo;
			if (x > hi)
				x = hi;
			return ((x - lo) * ((longint'(1) << bits) - 1)) / (hi - lo);
		endfunction

		function void note_command(motor_cmd_t c);
			logic [FRAME_W-1:0] frame;
			if (c.kind == KIND_UNUSED)
				return;
			case (c.kind)
				KIND_CONTROL: begin
					frame = {16'(lane_code(c.pos, -POS_LIM, POS_LIM, 16)),
						12'(lane_code(c.vel, -VEL_LIM, VEL_LIM, 12)),
						12'(lane_code(c.kp, 0, KP_MAX, 12)),
						12'(lane_code(c.kd, 0, KD_MAX, 12)),
						12'(lane_code(c.tq, -TQ_LIM, TQ_LIM, 12))};
				end
				KIND_SPEED_MODE: frame = {CMD_PREFIX, CMD_SPEED_MODE};
				KIND_POS_MODE:   frame = {CMD_PREFIX, CMD_POS_MODE};
				KIND_ENTER:      frame = {CMD_PREFIX, CMD_ENTER};
				KIND_EXIT:       frame = {CMD_PREFIX, CMD_EXIT};
				KIND_TURN_RESET: frame = {CMD_PREFIX, CMD_TURN_RESET};
				default:         frame = {CMD_PREFIX, CMD_ZERO};
			endcase
			pending_ids.push_back(c.node_id);
			pending_frames.push_back(frame);
		endfunction

		function void check_frame(logic [M_TDATA_W-1:0] beat);
			logic [ID_W-1:0]    got_id;
			logic [FRAME_W-1:0] got_frame;
			logic [ID_W-1:0]    want_id;
			logic [FRAME_W-1:0] want_frame;
			got_id = beat[ID_W-1:0];
			got_frame = beat[ID_W +: FRAME_W];
			if (pending_ids.size() == 0) begin
				$error("unexpected frame: frame_id %0h frame_bytes %016h", got_id, got_frame);
				errors++;
				return;
			end
			want_id = pending_ids.pop_front();
			want_frame = pending_frames.pop_front();
			if (got_id !== want_id) begin
				$error("frame_id: expected %0h, got %0h", want_id, got_id);
				errors++;
			end
			if (got_frame !== want_frame) begin
				$error("frame_bytes: expected %016h, got %016h", want_frame, got_frame);
				errors++;
			end
		endfunction

		function int pending();
			return pending_ids.size();
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n = 1'b0;
	logic                 s_axis_tvalid = 1'b0;
	logic                 s_axis_tready;
	logic [S_TDATA_W-1:0] s_axis_tdata = '0;
	logic [S_TUSER_W-1:0] s_axis_tuser = '0;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_axis_tdata;

	frame_scoreboard sb = new();
	int  send_idle_pct = 0;
	int  stall_pct = 0;
	bit  hold_req = 1'b0;
	int  quiet_cycles = 0;

	motor_command_frame_encoder_top u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// receiver: random stalls, plus one long hold-off on request
	initial begin
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				m_axis_tready <= 1'b0;
				repeat (PRESSURE_CYCLES) @(posedge clk);
			end
			m_axis_tready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// handshakes are sampled mid-cycle, where everything driven at the edge has settled
	always @(negedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready)
				sb.check_frame(m_axis_tdata);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("tb_top: FAIL");
				$finish;
			end
		end
	end

	function automatic motor_cmd_t make_command(logic [2:0] kind, logic [ID_W-1:0] node_id,
			longint pos, longint vel, longint kp, longint kd, longint tq);
		motor_cmd_t c;
		c.kind = kind;
		c.node_id = node_id;
		c.pos = SET_W'(pos);
		c.vel = SET_W'(vel);
		c.kp = SET_W'(kp);
		c.kd = SET_W'(kd);
		c.tq = SET_W'(tq);
		return c;
	endfunction

	// mostly in range, with a fair share near the limits and beyond them
	function automatic longint random_setpoint(longint lo, longint hi);
		case ($urandom_range(9))
			0, 1:    return longint'($signed(SET_W'($urandom)));
			2:       return lo + longint'($urandom_range(6)) - 3;
			3:       return hi + longint'($urandom_range(6)) - 3;
			4:       return $urandom_range(1) ? SET_MIN : SET_MAX;
			default: return lo + longint'($urandom_range(int'(hi - lo)));
		endcase
	endfunction

	function automatic motor_cmd_t random_command();
		int          pick;
		logic [2:0]  kind;
		pick = $urandom_range(99);
		if (pick < 72)
			kind = KIND_CONTROL;
		else if (pick < 97)
			kind = 3'($urandom_range(KIND_ZERO, KIND_SPEED_MODE));
		else
			kind = KIND_UNUSED;
		return make_command(kind, ID_W'($urandom),
			random_setpoint(-POS_LIM, POS_LIM), random_setpoint(-VEL_LIM, VEL_LIM),
			random_setpoint(0, KP_MAX), random_setpoint(0, KD_MAX),
			random_setpoint(-TQ_LIM, TQ_LIM));
	endfunction

	// called and returns at a rising edge; tvalid is left high after the beat
	task automatic send_command(motor_cmd_t c);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= c.kind;
		s_axis_tdata <= S_TDATA_W'({c.tq, c.kd, c.kp, c.vel, c.pos, c.node_id});
		do begin
			@(negedge clk);
		end while (!s_axis_tready);
		sb.note_command(c);
		@(posedge clk);
	endtask

	task automatic run_directed();
		send_command(make_command(KIND_CONTROL, 11'd0, 0, 0, 0, 0, 0));
		send_command(make_command(KIND_CONTROL, 11'h7FF, -POS_LIM, -VEL_LIM, 0, 0, -TQ_LIM));
		// exact maxima give all-ones codes
		send_command(make_command(KIND_CONTROL, 11'h400, POS_LIM, VEL_LIM, KP_MAX, KD_MAX,
			TQ_LIM));
		send_command(make_command(KIND_CONTROL, 11'h001, -POS_LIM - 1, -VEL_LIM - 1, -1, -1,
			-TQ_LIM - 1));
		send_command(make_command(KIND_CONTROL, 11'h3FF, POS_LIM + 1, VEL_LIM + 1, KP_MAX + 1,
			KD_MAX + 1, TQ_LIM + 1));
		send_command(make_command(KIND_CONTROL, 11'h2AA, SET_MIN, SET_MIN, SET_MIN, SET_MIN,
			SET_MIN));
		send_command(make_command(KIND_CONTROL, 11'h555, SET_MAX, SET_MAX, SET_MAX, SET_MAX,
			SET_MAX));
		send_command(make_command(KIND_CONTROL, 11'h123, Q_ONE, -Q_ONE, Q_ONE, Q_ONE, -Q_ONE));
		send_command(make_command(KIND_CONTROL, 11'h0F0, POS_LIM - 1, VEL_LIM - 1, KP_MAX - 1,
			KD_MAX - 1, TQ_LIM - 1));
		send_command(make_command(KIND_CONTROL, 11'h70F, 1, 1, 1, 1, 1));
		send_command(make_command(KIND_CONTROL, 11'h555, 24'h555555, 24'hAAAAAA, 24'h555555,
			24'hAAAAAA, 24'h555555));
		// setpoints on command kinds must be ignored
		send_command(make_command(KIND_SPEED_MODE, 11'h011, SET_MAX, 0, SET_MIN, 5, -5));
		send_command(make_command(KIND_POS_MODE, 11'h022, -1, -1, -1, -1, -1));
		send_command(make_command(KIND_ENTER, 11'h044, 0, 0, 0, 0, 0));
		send_command(make_command(KIND_EXIT, 11'h088, Q_ONE, Q_ONE, Q_ONE, Q_ONE, Q_ONE));
		send_command(make_command(KIND_TURN_RESET, 11'h100, SET_MIN, SET_MAX, 0, 0, 0));
		send_command(make_command(KIND_ZERO, 11'h200, 7, 7, 7, 7, 7));
		// unused kind: accepted, no frame
		send_command(make_command(KIND_UNUSED, 11'h7FF, SET_MAX, SET_MAX, 0, 0, 0));
		send_command(make_command(KIND_CONTROL, 11'h6DB, -Q_ONE / 2, Q_ONE / 2, KP_MAX / 2,
			KD_MAX / 2, 0));
		send_command(make_command(KIND_UNUSED, 11'h000, 0, 0, 0, 0, 0));
		send_command(make_command(KIND_ZERO, 11'h7FF, 0, 0, 0, 0, 0));
	endtask

	initial begin
		motor_cmd_t c;
		int         sent;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		run_directed();
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin
					send_idle_pct = 0;
					stall_pct = 0;
					// long hold-off with the sender busy: queue fills, tready drops
					hold_req = 1'b1;
				end
				1: begin
					send_idle_pct = 82;
					stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					stall_pct = 82;
				end
				default: begin
					send_idle_pct = 32;
					stall_pct = 32;
				end
			endcase
			sent = 0;
			while (sent < RANDOM_ITEMS / 4) begin
				c = random_command();
				send_command(c);
				if (c.kind != KIND_UNUSED)
					sent++;
			end
		end
		s_axis_tvalid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end

endmodule
